@@ hdl/oldest_reader_generation_tracker_defines.svh @@
// Assertion macros shared by the tracker RTL.
`ifndef OLDEST_READER_GENERATION_TRACKER_DEFINES_SVH
`define OLDEST_READER_GENERATION_TRACKER_DEFINES_SVH

`define ORT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

`define ORT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ORT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ort_pkg.sv @@
package ort_pkg;

    localparam int READER_SLOTS = 64;
    localparam int SLOT_W       = $clog2(READER_SLOTS);
    localparam int PTR_W        = $clog2(2 * READER_SLOTS);
    localparam int GEN_W        = 32;
    localparam int OCC_W        = 7;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [PTR_W:0]    t_ptr_wide;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    function automatic t_ptr ptr_next(input t_ptr p);
        return (p == t_ptr'(2 * READER_SLOTS - 1)) ? '0 : t_ptr'(p + t_ptr'(1));
    endfunction

    function automatic t_slot ptr_slot(input t_ptr p);
        return (p >= t_ptr'(READER_SLOTS)) ? t_slot'(p - t_ptr'(READER_SLOTS)) : t_slot'(p);
    endfunction

    function automatic t_ptr ring_count(input t_ptr head, input t_ptr tail);
        t_ptr_wide wrapped;
        wrapped = t_ptr_wide'({1'b0, tail}) + t_ptr_wide'(2 * READER_SLOTS)
                - t_ptr_wide'({1'b0, head});
        return (tail >= head) ? t_ptr'(tail - head) : t_ptr'(wrapped);
    endfunction

endpackage

@@ hdl/ort_gen_ram.sv @@
module ort_gen_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/oldest_reader_generation_tracker.sv @@
// Tracks reader generations in a ring of slots and reports the oldest live one.
// Input channel: i_in_valid / o_in_ready with i_action (add, remove, query)
// and i_generation. Output channel: o_out_valid / i_out_ready with o_status,
// o_oldest_generation and o_occupancy; every input beat gives one output beat.
// Generations sit in a single-port-read synchronous RAM; active bits are flops.
// An add or a query goes from acceptance to S_FETCH, which reads the RAM at
// the head, and then to S_RESP, which loads the output register.
// A remove scans the ring from the head, one RAM read per cycle with the
// compare in the cycle after each read, then steps the head one slot per
// cycle over inactive slots, at most to the slot just after the matched one,
// and then takes the same S_FETCH and S_RESP steps. Without a match it goes
// to S_FETCH once the scan has read every occupied slot.
// One item is processed at a time; o_in_ready is high only between items.
// The result sits in an output register, so a new beat is accepted while it
// waits; a stalled receiver holds the block before its next result is loaded.
// Reset clears the head, the tail, all active bits and the output valid.
// No clearing pass is needed after reset.
`include "oldest_reader_generation_tracker_defines.svh"

module oldest_reader_generation_tracker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_action,
    input  logic [ort_pkg::GEN_W-1:0] i_generation,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic [ort_pkg::GEN_W-1:0] o_oldest_generation,
    output logic [ort_pkg::OCC_W-1:0] o_occupancy
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SEARCH  = 3'd1;
    localparam logic [2:0] S_ADVANCE = 3'd2;
    localparam logic [2:0] S_FETCH   = 3'd3;
    localparam logic [2:0] S_RESP    = 3'd4;

    logic [2:0] r_state, n_state;
    ort_pkg::t_ptr r_head, n_head;
    ort_pkg::t_ptr r_tail, n_tail;
    logic [ort_pkg::READER_SLOTS-1:0] r_active, n_active;
    logic r_out_valid, n_out_valid;
    logic r_cmp_valid, n_cmp_valid;

    logic [ort_pkg::GEN_W-1:0] r_gen, n_gen;
    logic [1:0] r_status, n_status;
    ort_pkg::t_ptr r_scan_ptr, n_scan_ptr;
    ort_pkg::t_ptr r_scan_cnt, n_scan_cnt;
    ort_pkg::t_ptr r_cmp_ptr, n_cmp_ptr;
    ort_pkg::t_ptr r_cmp_off, n_cmp_off;
    ort_pkg::t_ptr r_hit_off, n_hit_off;
    ort_pkg::t_ptr r_adv_cnt, n_adv_cnt;
    logic [1:0] r_out_status, n_out_status;
    logic [ort_pkg::GEN_W-1:0] r_out_oldest, n_out_oldest;
    logic [ort_pkg::OCC_W-1:0] r_out_occ, n_out_occ;

    logic ram_we;
    ort_pkg::t_slot ram_waddr;
    logic ram_re;
    ort_pkg::t_slot ram_raddr;
    logic [ort_pkg::GEN_W-1:0] ram_rdata;

    ort_pkg::t_ptr w_count;
    logic w_accept;
    logic w_issue;
    logic w_hit;

    ort_gen_ram #(
        .DEPTH(ort_pkg::READER_SLOTS),
        .WIDTH(ort_pkg::GEN_W)
    ) u_gen_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(ram_waddr),
        .i_wr_data(i_generation),
        .i_rd_en  (ram_re),
        .i_rd_addr(ram_raddr),
        .o_rd_data(ram_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_count    = ort_pkg::ring_count(r_head, r_tail);
    assign w_issue    = (r_scan_cnt < w_count);
    assign w_hit      = r_cmp_valid && r_active[ort_pkg::ptr_slot(r_cmp_ptr)]
                        && (ram_rdata == r_gen);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_active     = r_active;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_cmp_valid  = 1'b0;
        n_gen        = r_gen;
        n_status     = r_status;
        n_scan_ptr   = r_scan_ptr;
        n_scan_cnt   = r_scan_cnt;
        n_cmp_ptr    = r_cmp_ptr;
        n_cmp_off    = r_cmp_off;
        n_hit_off    = r_hit_off;
        n_adv_cnt    = r_adv_cnt;
        n_out_status = r_out_status;
        n_out_oldest = r_out_oldest;
        n_out_occ    = r_out_occ;
        ram_we       = 1'b0;
        ram_waddr    = ort_pkg::ptr_slot(r_tail);
        ram_re       = 1'b0;
        ram_raddr    = ort_pkg::ptr_slot(r_head);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_gen    = i_generation;
                    n_status = ort_pkg::STAT_OK;
                    n_state  = S_FETCH;
                    case (i_action)
                        ort_pkg::ACT_ADD: begin
                            if (w_count < ort_pkg::t_ptr'(ort_pkg::READER_SLOTS)) begin
                                n_tail = ort_pkg::ptr_next(r_tail);
                                n_active[ort_pkg::ptr_slot(r_tail)] = 1'b1;
                            end else begin
                                n_status = ort_pkg::STAT_FULL;
                            end
                        end
                        ort_pkg::ACT_REMOVE: begin
                            if (w_count == '0) begin
                                n_status = ort_pkg::STAT_NOT_FOUND;
                            end else begin
                                n_scan_ptr = r_head;
                                n_scan_cnt = '0;
                                n_state    = S_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    n_active[ort_pkg::ptr_slot(r_cmp_ptr)] = 1'b0;
                    n_hit_off = r_cmp_off;
                    n_adv_cnt = '0;
                    n_state   = S_ADVANCE;
                end else if (!w_issue) begin
                    n_status = ort_pkg::STAT_NOT_FOUND;
                    n_state  = S_FETCH;
                end else begin
                    ram_re      = 1'b1;
                    ram_raddr   = ort_pkg::ptr_slot(r_scan_ptr);
                    n_cmp_valid = 1'b1;
                    n_cmp_ptr   = r_scan_ptr;
                    n_cmp_off   = r_scan_cnt;
                    n_scan_ptr  = ort_pkg::ptr_next(r_scan_ptr);
                    n_scan_cnt  = ort_pkg::t_ptr'(r_scan_cnt + ort_pkg::t_ptr'(1));
                end
            end
            S_ADVANCE: begin
                if ((r_adv_cnt > r_hit_off) || r_active[ort_pkg::ptr_slot(r_head)]) begin
                    n_state = S_FETCH;
                end else begin
                    n_head    = ort_pkg::ptr_next(r_head);
                    n_adv_cnt = ort_pkg::t_ptr'(r_adv_cnt + ort_pkg::t_ptr'(1));
                end
            end
            S_FETCH: begin
                ram_re  = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_oldest = (w_count != '0) ? ram_rdata : '1;
                    n_out_occ    = ort_pkg::OCC_W'(w_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_state == S_IDLE && w_accept && i_action == ort_pkg::ACT_ADD
                && w_count < ort_pkg::t_ptr'(ort_pkg::READER_SLOTS)) begin
            ram_we = 1'b1;
        end
    end

    // An add writes the RAM at the accepting edge; these registers record that
    // write and its slot so the check below can look at that slot.
    logic r_wr_pend;
    ort_pkg::t_slot r_wr_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_cmp_valid <= n_cmp_valid;
            r_wr_pend   <= ram_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gen        <= n_gen;
        r_status     <= n_status;
        r_scan_ptr   <= n_scan_ptr;
        r_scan_cnt   <= n_scan_cnt;
        r_cmp_ptr    <= n_cmp_ptr;
        r_cmp_off    <= n_cmp_off;
        r_hit_off    <= n_hit_off;
        r_adv_cnt    <= n_adv_cnt;
        r_out_status <= n_out_status;
        r_out_oldest <= n_out_oldest;
        r_out_occ    <= n_out_occ;
        r_wr_slot    <= ram_waddr;
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out_status;
    assign o_oldest_generation = r_out_oldest;
    assign o_occupancy         = r_out_occ;

    `ORT_ASSERT_ALWAYS(a_count_bound, (w_count <= ort_pkg::t_ptr'(ort_pkg::READER_SLOTS)), "ring occupancy exceeds slot count")

    `ORT_ASSERT_NEXT(a_search_keeps_ptrs, (r_state == S_SEARCH), ((r_tail == $past(r_tail)) && (r_head == $past(r_head))), "pointers moved during search")

    `ORT_ASSERT_IMPLIES(a_full_at_capacity, (r_out_valid && (o_status == ort_pkg::STAT_FULL)), (o_occupancy == ort_pkg::OCC_W'(ort_pkg::READER_SLOTS)), "full status below capacity")

    `ORT_ASSERT_IMPLIES(a_add_sets_active, r_wr_pend, r_active[r_wr_slot], "added slot is not active")

endmodule

@@ verif/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam logic [ort_pkg::GEN_W-1:0] NO_READER = '1;
    localparam int unsigned PTR_SPAN = 2 * ort_pkg::READER_SLOTS;
    localparam int RANDOM_EVENTS = 1600;
    localparam int SETTLE_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 1_500_000;

    typedef struct {
        logic [1:0]                action;
        logic [ort_pkg::GEN_W-1:0] generation;
        bit                        wait_drain;
    } t_reader_event;

    typedef struct {
        logic [1:0]                status;
        logic [ort_pkg::GEN_W-1:0] oldest;
        logic [ort_pkg::OCC_W-1:0] occupancy;
    } t_ring_snapshot;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_action = ACT_QUERY;
    logic [ort_pkg::GEN_W-1:0] i_generation = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [1:0]                o_status;
    logic [ort_pkg::GEN_W-1:0] o_oldest_generation;
    logic [ort_pkg::OCC_W-1:0] o_occupancy;

    t_reader_event  reader_events[$];
    t_ring_snapshot expected_snapshots[$];
    logic [ort_pkg::GEN_W-1:0] live_gens[$];
    t_reader_event  presented;

    logic [ort_pkg::GEN_W-1:0] shadow_gen [ort_pkg::READER_SLOTS];
    bit                        shadow_live [ort_pkg::READER_SLOTS];
    int unsigned               shadow_head;
    int unsigned               shadow_tail;

    int     beats_sent = 0;
    int     beats_seen = 0;
    int     planned_beats = 0;
    int     idle_phase = 0;
    int     error_count = 0;
    longint cycle_count = 0;

    oldest_reader_generation_tracker i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_generation        (i_generation),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_oldest_generation (o_oldest_generation),
        .o_occupancy         (o_occupancy)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned ring_fill();
        return (shadow_tail + PTR_SPAN - shadow_head) % PTR_SPAN;
    endfunction

    function automatic t_ring_snapshot apply_reader_event(logic [1:0] action,
                                                          logic [ort_pkg::GEN_W-1:0] gen);
        t_ring_snapshot snap;
        int unsigned fill;
        int unsigned slot;
        int unsigned hit;
        bit found;
        bit blocked;
        snap.status = ort_pkg::STAT_OK;
        fill = ring_fill();
        hit = 0;
        found = 1'b0;
        blocked = 1'b0;
        if (action == ort_pkg::ACT_ADD) begin
            if (fill >= ort_pkg::READER_SLOTS) begin
                snap.status = ort_pkg::STAT_FULL;
            end else begin
                slot = shadow_tail % ort_pkg::READER_SLOTS;
                shadow_gen[slot] = gen;
                shadow_live[slot] = 1'b1;
                shadow_tail = (shadow_tail + 1) % PTR_SPAN;
            end
        end else if (action == ort_pkg::ACT_REMOVE) begin
            for (int unsigned k = 0; k < fill; k++) begin
                slot = ((shadow_head + k) % PTR_SPAN) % ort_pkg::READER_SLOTS;
                if (!found && shadow_live[slot] && shadow_gen[slot] == gen) begin
                    shadow_live[slot] = 1'b0;
                    found = 1'b1;
                    hit = k;
                end
            end
            if (!found) begin
                snap.status = ort_pkg::STAT_NOT_FOUND;
            end else begin
                // The head stops at the first live slot, or at the slot just after the cleared one.
                for (int unsigned j = 0; j <= hit; j++) begin
                    if (!blocked && shadow_live[shadow_head % ort_pkg::READER_SLOTS]) begin
                        blocked = 1'b1;
                    end else if (!blocked) begin
                        shadow_head = (shadow_head + 1) % PTR_SPAN;
                    end
                end
            end
        end
        fill = ring_fill();
        snap.occupancy = ort_pkg::OCC_W'(fill);
        snap.oldest = (fill > 0) ? shadow_gen[shadow_head % ort_pkg::READER_SLOTS] : NO_READER;
        return snap;
    endfunction

    function automatic logic [ort_pkg::GEN_W-1:0] pick_generation();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return ort_pkg::GEN_W'(32'h7000_0000 + $urandom_range(0, 7));
        end else if (roll < 65) begin
            return ($urandom_range(0, 1) != 0) ? NO_READER : '0;
        end else begin
            return ort_pkg::GEN_W'($urandom());
        end
    endfunction

    task automatic push_event(logic [1:0] action, logic [ort_pkg::GEN_W-1:0] gen,
                              bit wait_drain);
        t_reader_event ev;
        ev.action = action;
        ev.generation = gen;
        ev.wait_drain = wait_drain;
        reader_events.insert(reader_events.size(), ev);
        if (action == ort_pkg::ACT_ADD && live_gens.size() < ort_pkg::READER_SLOTS) begin
            live_gens.insert(live_gens.size(), gen);
        end
    endtask

    task automatic push_live_removal(bit wait_drain);
        int unsigned idx;
        logic [ort_pkg::GEN_W-1:0] gen;
        if (live_gens.size() == 0) begin
            push_event(ort_pkg::ACT_REMOVE, pick_generation(), wait_drain);
        end else begin
            idx = $urandom_range(0, live_gens.size() - 1);
            gen = live_gens[idx];
            live_gens.delete(idx);
            push_event(ort_pkg::ACT_REMOVE, gen, wait_drain);
        end
    endtask

    task automatic build_stimulus();
        int unsigned mode;
        int unsigned burst;
        int unsigned roll;
        push_event(ACT_QUERY, '0, 1'b0);
        push_event(ort_pkg::ACT_REMOVE, '0, 1'b0);
        push_event(ort_pkg::ACT_ADD, '0, 1'b0);
        push_event(ort_pkg::ACT_ADD, NO_READER, 1'b0);
        push_event(ort_pkg::ACT_ADD, 32'h1234_5678, 1'b0);
        push_event(ort_pkg::ACT_ADD, NO_READER, 1'b0);
        push_event(ACT_SPARE, 32'hAAAA_AAAA, 1'b0);
        push_event(ort_pkg::ACT_REMOVE, NO_READER, 1'b0);
        push_event(ort_pkg::ACT_REMOVE, '0, 1'b0);
        push_event(ACT_QUERY, 32'h5555_5555, 1'b0);
        push_event(ort_pkg::ACT_REMOVE, 32'h1234_5678, 1'b0);
        push_event(ort_pkg::ACT_REMOVE, 32'h5555_5555, 1'b0);
        push_event(ort_pkg::ACT_REMOVE, NO_READER, 1'b0);
        push_event(ort_pkg::ACT_ADD, 32'h5555_5555, 1'b0);
        push_event(ort_pkg::ACT_ADD, 32'hAAAA_AAAA, 1'b0);
        push_event(ort_pkg::ACT_REMOVE, 32'hAAAA_AAAA, 1'b0);
        push_event(ort_pkg::ACT_REMOVE, 32'h5555_5555, 1'b0);
        push_event(ort_pkg::ACT_ADD, 32'h0000_0001, 1'b0);
        push_event(ort_pkg::ACT_REMOVE, 32'h5555_5555, 1'b0);
        live_gens.delete();
        live_gens.insert(0, 32'h0000_0001);

        // Fill past capacity once, then remove every live generation again.
        for (int i = 0; i < ort_pkg::READER_SLOTS + 4; i++) begin
            push_event(ort_pkg::ACT_ADD, pick_generation(), i == 0);
        end
        while (live_gens.size() > 0) begin
            push_live_removal(1'b0);
        end

        while (reader_events.size() < RANDOM_EVENTS) begin
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
                burst = $urandom_range(30, ort_pkg::READER_SLOTS + 6);
                for (int unsigned i = 0; i < burst; i++) begin
                    push_event(ort_pkg::ACT_ADD, pick_generation(), 1'b0);
                end
            end else if (mode < 4) begin
                burst = $urandom_range(1, live_gens.size() + 2);
                for (int unsigned i = 0; i < burst; i++) begin
                    push_live_removal(1'b0);
                end
            end else begin
                for (int i = 0; i < 20; i++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 38) begin
                        push_event(ort_pkg::ACT_ADD, pick_generation(), 1'b0);
                    end else if (roll < 73) begin
                        push_live_removal(1'b0);
                    end else if (roll < 85) begin
                        push_event(ort_pkg::ACT_REMOVE, pick_generation(), 1'b0);
                    end else if (roll < 95) begin
                        push_event(ACT_QUERY, ort_pkg::GEN_W'($urandom()), 1'b0);
                    end else begin
                        push_event(ACT_SPARE, ort_pkg::GEN_W'($urandom()), 1'b0);
                    end
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                reader_events[reader_events.size() - 1].wait_drain = 1'b1;
            end
        end
    endtask

    function automatic int send_idle_pct(int phase);
        return (phase == 0) ? 13 : (phase == 1) ? 78 : 0;
    endfunction

    function automatic int recv_stall_pct(int phase);
        return (phase == 0) ? 78 : (phase == 1) ? 13 : 0;
    endfunction

    always @(posedge i_clk) begin : event_driver
        bit fire;
        bit go;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            shadow_head = 0;
            shadow_tail = 0;
            for (int s = 0; s < ort_pkg::READER_SLOTS; s++) begin
                shadow_live[s] = 1'b0;
            end
        end else begin
            fire = i_in_valid && o_in_ready;
            if (fire) begin
                expected_snapshots.insert(expected_snapshots.size(),
                    apply_reader_event(presented.action, presented.generation));
                beats_sent++;
            end
            idle_phase <= (beats_sent < planned_beats / 3) ? 0 :
                          (beats_sent < 2 * planned_beats / 3) ? 1 : 2;
            if (!i_in_valid || fire) begin
                go = 1'b0;
                if (reader_events.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct(idle_phase)) begin
                    go = !reader_events[0].wait_drain || beats_sent == beats_seen;
                end
                if (go) begin
                    presented = reader_events[0];
                    reader_events.delete(0);
                    i_action <= presented.action;
                    i_generation <= presented.generation;
                end
                i_in_valid <= go;
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_ring_snapshot want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                beats_seen <= beats_seen + 1;
                if (expected_snapshots.size() == 0) begin
                    $display("%0t: unexpected result beat: status %0d oldest %h occupancy %0d",
                             $time, o_status, o_oldest_generation, o_occupancy);
                    error_count++;
                end else begin
                    want = expected_snapshots[0];
                    expected_snapshots.delete(0);
                    if (o_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, o_status);
                        error_count++;
                    end
                    if (o_oldest_generation !== want.oldest) begin
                        $display("%0t: oldest generation mismatch: expected %h, actual %h",
                                 $time, want.oldest, o_oldest_generation);
                        error_count++;
                    end
                    if (o_occupancy !== want.occupancy) begin
                        $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                                 $time, want.occupancy, o_occupancy);
                        error_count++;
                    end
                end
            end
            i_out_ready <= $urandom_range(0, 99) >= recv_stall_pct(idle_phase);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        planned_beats = reader_events.size();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (reader_events.size() != 0 || i_in_valid || beats_seen != beats_sent) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_snapshots.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (expected_snapshots.size() != 0) begin
                $display("%0t: %0d expected results never arrived",
                         $time, expected_snapshots.size());
            end
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
